// ===== rtl/bbcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcm_pkg
// Shared types and constants of the block buffer cache manager.
// ----------------------------------------------------------------------------
package bbcm_pkg;

   localparam int DefNumSlots  = 16;
   localparam logic [31:0] DefDiskBlocks = 32'd1024;
   localparam int SlotOutW   = 4;

   typedef enum logic [2:0] {
      CMD_GET     = 3'd0,
      CMD_READ    = 3'd1,
      CMD_RELEASE = 3'd2,
      CMD_WRITE   = 3'd3,
      CMD_DIRTY   = 3'd4,
      CMD_SYNC    = 3'd5,
      CMD_BAD6    = 3'd6,
      CMD_BAD7    = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_NOFREE  = 3'd2,
      ST_BADREL  = 3'd3,
      ST_DONE    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FILL_NONE = 2'd0,
      FILL_DISK = 2'd1,
      FILL_ZERO = 2'd2
   } fill_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_LOOKUP = 2'd1,
      FSM_SYNC   = 2'd2,
      FSM_OUT    = 2'd3
   } fsm_type;

   // lru queue operation handed to the cell row
   typedef struct packed {
      logic       remove;
      logic [5:0] remove_slot;
      logic       append;
      logic [5:0] append_slot;
   } lru_op_type;

endpackage

// ===== rtl/bbcm_lru_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcm_lru_cell
// One place of the free order: holds a slot number and shifts towards head.
// ----------------------------------------------------------------------------
module bbcm_lru_cell #(
   parameter int SLOT_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] reset_slot,
   input  logic              shift,      // take the neighbour's entry
   input  logic              load,       // take the appended entry
   input  logic [SLOT_W-1:0] next_slot,
   input  logic [SLOT_W-1:0] load_slot,
   output logic [SLOT_W-1:0] slot
);

   logic [SLOT_W-1:0] slot_ff, slot_in;

   // entry select
   always_comb begin
      slot_in = slot_ff;
      if (load)       slot_in = load_slot;
      else if (shift) slot_in = next_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) slot_ff <= reset_slot;
      else       slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

// ===== rtl/bbcm_lru_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcm_lru_row
// Row of free order cells with the free length count; removal closes the gap
// by shifting the tail one place towards the head, append writes the tail.
// ----------------------------------------------------------------------------
module bbcm_lru_row #(
   parameter int NUM_SLOTS = bbcm_pkg::DefNumSlots,
   parameter int SLOT_W    = $clog2(NUM_SLOTS),
   parameter int LEN_W     = $clog2(NUM_SLOTS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bbcm_pkg::lru_op_type op,
   output logic [SLOT_W-1:0]    head,
   output logic [LEN_W-1:0]     length
);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [SLOT_W-1:0] slots [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] match, past;
   logic [NUM_SLOTS-1:0] shift, load;
   logic [LEN_W-1:0] tail;

   // locate the removed entry within the live part
   always_comb begin
      for (int p = 0; p < NUM_SLOTS; p++) begin
         match[p] = op.remove && (LEN_W'(p) < len_ff)
                    && (slots[p] == op.remove_slot[SLOT_W-1:0]);
      end
      past[0] = match[0];
      for (int p = 1; p < NUM_SLOTS; p++) past[p] = past[p-1] | match[p];
   end

   // length and tail place after removal
   always_comb begin
      len_in = len_ff;
      if (|match) len_in = len_ff - LEN_W'(1);
      tail = len_in;
      if (op.append && (len_in < LEN_W'(NUM_SLOTS))) len_in = len_in + LEN_W'(1);
      for (int p = 0; p < NUM_SLOTS; p++) begin
         shift[p] = past[p];
         load[p]  = op.append && (tail == LEN_W'(p));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) len_ff <= LEN_W'(NUM_SLOTS);
      else       len_ff <= len_in;
   end

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      logic [SLOT_W-1:0] nxt;
      if (g == NUM_SLOTS - 1) begin : g_end
         assign nxt = slots[g];
      end else begin : g_mid
         assign nxt = slots[g+1];
      end
      bbcm_lru_cell #(.SLOT_W(SLOT_W)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .reset_slot (SLOT_W'(g)),
         .shift      (shift[g]),
         .load       (load[g]),
         .next_slot  (nxt),
         .load_slot  (op.append_slot[SLOT_W-1:0]),
         .slot       (slots[g])
      );
   end

   assign head   = slots[0];
   assign length = len_ff;

endmodule

// ===== rtl/block_buffer_cache_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_manager_unit
// Bookkeeping of a block buffer cache: tag lookup, reference counts, marks,
// lru free order held in a row of shifting cells, and sync flush walk.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  req_    | in  | tdata: cmd, block_number, slot_index
//  rsp_    | out | tdata: status, slot_out, was_locked, fill_kind,
//          |     |        writeback_valid, writeback_block, flush_count; tlast
//  csr_    | apb | disk_blocks at address 0
//
// each command is accepted, then looked up and applied in a single step, then
// answered with the response beat; codes 6 and 7 return to idle with no beat.
// sync walks one slot per cycle while no beat waits, with a beat per flushed slot.
// reset is synchronous and returns every slot and the free order to start.
// a stalled response holds the block; the next request waits for it.
// ----------------------------------------------------------------------------
module block_buffer_cache_manager_unit #(
   parameter int NUM_SLOTS = bbcm_pkg::DefNumSlots
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[2:0], block_number[34:3], slot_index[38:35], zero pad
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], slot_out[6:3], was_locked[7], fill_kind[9:8],
   // writeback_valid[10], writeback_block[42:11], flush_count[47:43]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LEN_W  = $clog2(NUM_SLOTS + 1);
   localparam int IDX_W  = $clog2(NUM_SLOTS + 1);

   // configuration
   logic [31:0] disk_ff, disk_in;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? disk_ff : 32'd0;
   always_comb begin
      disk_in = disk_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         disk_in = csr_pwdata;
   end

   // slot state
   logic [31:0]          tag_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff, dirty_ff, locked_ff;
   logic [7:0]           refs_ff [NUM_SLOTS];

   // request capture
   bbcm_pkg::cmd_type cmd_ff;
   logic [31:0] blk_ff;
   logic [3:0]  si_ff;
   bbcm_pkg::fsm_type st_ff, st_in;
   logic [IDX_W-1:0] walk_ff, walk_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [47:0] out_ff, out_in;
   logic last_ff, last_in;
   logic [NUM_SLOTS-1:0] found_ff;

   logic [SLOT_W-1:0] head;
   logic [LEN_W-1:0]  length;
   bbcm_pkg::lru_op_type op;

   wire req_acc = req_tvalid && req_tready;
   wire rsp_acc = rsp_tvalid && rsp_tready;

   // lookup match vector, registered at capture
   logic [NUM_SLOTS-1:0] hit_vec;
   always_comb
      for (int i = 0; i < NUM_SLOTS; i++)
         hit_vec[i] = valid_ff[i] && (tag_ff[i] == req_tdata[34:3]);

   // priority encode the registered match
   logic [SLOT_W-1:0] hit_idx;
   always_comb begin
      hit_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--)
         if (found_ff[i]) hit_idx = SLOT_W'(i);
   end

   wire si_ok = ({28'd0, si_ff} < 32'(NUM_SLOTS));
   wire [SLOT_W-1:0] si_s = SLOT_W'(si_ff);
   wire [SLOT_W-1:0] wk_s = walk_ff[SLOT_W-1:0];

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         bbcm_pkg::FSM_IDLE:   if (req_acc) st_in = bbcm_pkg::FSM_LOOKUP;
         bbcm_pkg::FSM_LOOKUP: begin
            if (cmd_ff == bbcm_pkg::CMD_SYNC) st_in = bbcm_pkg::FSM_SYNC;
            else if (cmd_ff == bbcm_pkg::CMD_BAD6 || cmd_ff == bbcm_pkg::CMD_BAD7)
               st_in = bbcm_pkg::FSM_IDLE;
            else st_in = bbcm_pkg::FSM_OUT;
         end
         bbcm_pkg::FSM_SYNC: begin
            if (walk_ff == IDX_W'(NUM_SLOTS)) st_in = bbcm_pkg::FSM_OUT;
            else if (dirty_ff[wk_s] && tag_ff[wk_s] < disk_ff)
               st_in = bbcm_pkg::FSM_OUT;
         end
         bbcm_pkg::FSM_OUT: if (rsp_acc)
            st_in = (last_ff) ? bbcm_pkg::FSM_IDLE : bbcm_pkg::FSM_SYNC;
         default: st_in = bbcm_pkg::FSM_IDLE;
      endcase
   end

   // outputs of the sequencer
   assign req_tready = (st_ff == bbcm_pkg::FSM_IDLE);
   assign rsp_tvalid = (st_ff == bbcm_pkg::FSM_OUT);
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = last_ff;

   function automatic logic [47:0] pack(input logic [2:0] s, input logic [3:0] sl,
      input logic wl, input logic [1:0] f, input logic wv, input logic [31:0] wb,
      input logic [4:0] c);
      pack = {c, wb, wv, f, wl, sl, s};
   endfunction

   // command execution
   logic [31:0]          tag_in [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_in, dirty_in, locked_in;
   logic [7:0]           refs_in [NUM_SLOTS];
   always_comb begin
      logic [SLOT_W-1:0] v;
      logic wv;
      v = head;
      wv = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         tag_in[i] = tag_ff[i];
         refs_in[i] = refs_ff[i];
      end
      valid_in = valid_ff; dirty_in = dirty_ff; locked_in = locked_ff;
      op = '0;
      out_in = out_ff; last_in = last_ff; walk_in = walk_ff; cnt_in = cnt_ff;
      if (st_ff == bbcm_pkg::FSM_LOOKUP) begin
         walk_in = '0; cnt_in = '0; last_in = 1'b1;
         unique case (cmd_ff)
            bbcm_pkg::CMD_GET, bbcm_pkg::CMD_READ: begin
               if (|found_ff) begin
                  if (refs_ff[hit_idx] == 8'd0) begin
                     op.remove = 1'b1; op.remove_slot = 6'(hit_idx);
                  end
                  if (refs_ff[hit_idx] != 8'hff) refs_in[hit_idx] = refs_ff[hit_idx] + 8'd1;
                  locked_in[hit_idx] = 1'b1;
                  out_in = pack(bbcm_pkg::ST_HIT, 4'(hit_idx), locked_ff[hit_idx],
                                bbcm_pkg::FILL_NONE, 1'b0, 32'd0, 5'd0);
               end else if (length == '0) begin
                  out_in = pack(bbcm_pkg::ST_NOFREE, 4'd0, 1'b0, bbcm_pkg::FILL_NONE,
                                1'b0, 32'd0, 5'd0);
               end else begin
                  op.remove = 1'b1; op.remove_slot = 6'(v);
                  wv = dirty_ff[v] && (tag_ff[v] < disk_ff);
                  tag_in[v] = blk_ff; dirty_in[v] = 1'b0; locked_in[v] = 1'b1;
                  refs_in[v] = 8'd1;
                  valid_in[v] = (cmd_ff == bbcm_pkg::CMD_READ);
                  out_in = pack(bbcm_pkg::ST_MISS, 4'(v), 1'b0,
                     (cmd_ff != bbcm_pkg::CMD_READ) ? bbcm_pkg::FILL_NONE :
                     (blk_ff < disk_ff) ? bbcm_pkg::FILL_DISK : bbcm_pkg::FILL_ZERO,
                     wv, wv ? tag_ff[v] : 32'd0, 5'd0);
               end
            end
            bbcm_pkg::CMD_RELEASE: begin
               if (!si_ok || refs_ff[si_s] == 8'd0) begin
                  out_in = pack(bbcm_pkg::ST_BADREL, si_ff, 1'b0, bbcm_pkg::FILL_NONE,
                                1'b0, 32'd0, 5'd0);
               end else begin
                  locked_in[si_s] = 1'b0;
                  refs_in[si_s] = refs_ff[si_s] - 8'd1;
                  if (refs_ff[si_s] == 8'd1) begin
                     op.append = 1'b1; op.append_slot = 6'(si_s);
                  end
                  out_in = pack(bbcm_pkg::ST_DONE, si_ff, 1'b0, bbcm_pkg::FILL_NONE,
                                1'b0, 32'd0, 5'd0);
               end
            end
            bbcm_pkg::CMD_WRITE: begin
               if (si_ok) begin
                  wv = tag_ff[si_s] < disk_ff;
                  dirty_in[si_s] = 1'b0;
               end
               out_in = pack(bbcm_pkg::ST_DONE, si_ff, 1'b0, bbcm_pkg::FILL_NONE,
                             wv, wv ? tag_ff[si_s] : 32'd0, 5'd0);
            end
            bbcm_pkg::CMD_DIRTY: begin
               if (si_ok) dirty_in[si_s] = 1'b1;
               out_in = pack(bbcm_pkg::ST_DONE, si_ff, 1'b0, bbcm_pkg::FILL_NONE,
                             1'b0, 32'd0, 5'd0);
            end
            default: ;
         endcase
      end else if (st_ff == bbcm_pkg::FSM_SYNC) begin
         if (walk_ff == IDX_W'(NUM_SLOTS)) begin
            last_in = 1'b1;
            out_in = pack(bbcm_pkg::ST_DONE, 4'd0, 1'b0, bbcm_pkg::FILL_NONE,
                          1'b0, 32'd0, cnt_ff);
         end else begin
            walk_in = walk_ff + IDX_W'(1);
            last_in = 1'b0;
            if (dirty_ff[wk_s] && tag_ff[wk_s] < disk_ff) begin
               dirty_in[wk_s] = 1'b0;
               if (cnt_ff != 5'd31) cnt_in = cnt_ff + 5'd1;
               out_in = pack(bbcm_pkg::ST_DONE, 4'(wk_s), 1'b0, bbcm_pkg::FILL_NONE,
                             1'b1, tag_ff[wk_s], 5'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= bbcm_pkg::FSM_IDLE;
         disk_ff <= bbcm_pkg::DefDiskBlocks;
         valid_ff <= '0; dirty_ff <= '0; locked_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            tag_ff[i] <= '1; refs_ff[i] <= '0;
         end
         last_ff <= 1'b0; walk_ff <= '0; cnt_ff <= '0;
      end else begin
         st_ff <= st_in; disk_ff <= disk_in;
         valid_ff <= valid_in; dirty_ff <= dirty_in; locked_ff <= locked_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            tag_ff[i] <= tag_in[i]; refs_ff[i] <= refs_in[i];
         end
         last_ff <= last_in; walk_ff <= walk_in; cnt_ff <= cnt_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (req_acc) begin
         cmd_ff <= bbcm_pkg::cmd_type'(req_tdata[2:0]);
         blk_ff <= req_tdata[34:3];
         si_ff <= req_tdata[38:35];
         found_ff <= hit_vec;
      end
   end

   bbcm_lru_row #(.NUM_SLOTS(NUM_SLOTS), .SLOT_W(SLOT_W), .LEN_W(LEN_W)) u_lru (
      .clock (clock), .reset (reset), .op (op), .head (head), .length (length)
   );

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request and response both open");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");
   a_len: assert property (@(posedge clock) disable iff (reset)
      length <= LEN_W'(NUM_SLOTS)) else $error("free length overflow");
`endif

endmodule
